### rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int QueueDepthDefault = 64;
  localparam int CountWidth = 7;

  localparam logic [1:0] CmdPush     = 2'd0;
  localparam logic [1:0] CmdPopFront = 2'd1;
  localparam logic [1:0] CmdPopBack  = 2'd2;
  localparam logic [1:0] CmdRemove   = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  localparam logic [1:0] ModeFG    = 2'd0;
  localparam logic [1:0] ModeFifo  = 2'd1;
  localparam logic [1:0] ModeStack = 2'd2;
  localparam logic [1:0] ModeDepth = 2'd3;

  localparam int EntryWidth = 96;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] f;
    logic [31:0] g;
    logic [15:0] depth;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_WRITE, S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat, clear scan index
    logic rd;         // issue read at scan index
    logic step;       // advance scan index
    logic wr;         // write memory
    logic wr_new;     // write the captured entry instead of shifted data
    logic dir_up;     // shift direction: 1 = insert (move toward back)
    logic take;       // latch read data as removed entry
    logic inc;        // count up
    logic dec;        // count down
    logic set_pos;    // set shift pointer
    logic shift_step; // move shift pointer
    logic [1:0] status;
    logic out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_end;   // scan index reached count
    logic pass;       // read entry passes (push) or matches (remove)
    logic shift_done;
    logic out_busy;
    logic [1:0] cmd;
  } sts_t;

endpackage

### rtl/core/sorted_priority_queue_modes.sv
// Sorted priority queue, controller plus datapath over one entry RAM.
// Time from accepted beat to result valid grows with each entry compared and each entry
// shifted, so it is set by the walk over the RAM.
// One command in flight; next beat accepted the cycle after its result is loaded,
// while that result may still wait in the output register.
// Reset (rst, synchronous): count zero, order_mode zero; RAM contents undefined.
module sorted_priority_queue_modes #(
  parameter int QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[1:0], entry_handle[17:2], cost_f[49:18], cost_g[81:50],
  // search_depth[97:82], zero pad
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], out_handle[17:2], out_f[49:18], out_g[81:50],
  // out_depth[97:82], entry_count[104:98], zero pad
  output logic [111:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import spq_pkg::*;

  logic [1:0] order_mode;
  ctl_t ctl;
  sts_t sts;
  entry_t in_entry;

  assign pready = 1'b1;
  assign prdata = {30'd0, order_mode};
  always_ff @(posedge clk) begin
    if (rst) order_mode <= ModeFG;
    else if (psel && penable && pwrite && paddr == 1'b0) order_mode <= pwdata[1:0];
  end

  assign in_entry = '{handle: s_tdata[17:2], f: s_tdata[49:18], g: s_tdata[81:50],
                      depth: s_tdata[97:82]};

  spq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready), .in_ready(s_tready),
    .sts(sts), .ctl(ctl)
  );

  spq_dp #(.QueueDepth(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .order_mode(order_mode), .in_cmd(s_tdata[1:0]),
    .in_entry(in_entry), .ctl(ctl), .sts(sts),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );
endmodule

### rtl/core/spq_ram.sv
module spq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/spq_ctrl.sv
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  output logic           in_ready,
  input  spq_pkg::sts_t  sts,
  output spq_pkg::ctl_t  ctl
);
  import spq_pkg::*;

  state_t state, state_next;
  logic   rd_pend, rd_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
    end
  end

  // Scan: each read is issued, then its registered data is compared before the next read.
  always_comb begin
    state_next   = state;
    rd_pend_next = 1'b0;
    ctl          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_pend) begin
          if (sts.cmd == CmdRemove) begin
            if (sts.pass) begin
              ctl.take    = 1'b1;
              ctl.set_pos = 1'b1;
              ctl.dec     = 1'b1;
              state_next  = S_SHIFT;
            end else begin
              ctl.step = 1'b1;
            end
          end else if (sts.cmd == CmdPush) begin
            if (sts.pass) ctl.step = 1'b1;
            else begin
              ctl.set_pos = 1'b1;
              state_next  = S_SHIFT;
            end
          end else begin
            ctl.take    = 1'b1;
            ctl.set_pos = 1'b1;
            ctl.dec     = 1'b1;
            state_next  = S_SHIFT;
          end
        end else if (sts.cmd == CmdPush && sts.full) begin
          ctl.status = StFull;
          state_next = S_RESULT;
        end else if ((sts.cmd == CmdPopFront || sts.cmd == CmdPopBack) && sts.empty) begin
          ctl.status = StEmpty;
          state_next = S_RESULT;
        end else if (sts.scan_end) begin
          if (sts.cmd == CmdPush) begin
            ctl.set_pos = 1'b1;
            state_next  = S_SHIFT;
          end else begin
            ctl.status = StNotFound;
            state_next = S_RESULT;
          end
        end else begin
          ctl.rd       = 1'b1;
          rd_pend_next = 1'b1;
        end
      end
      S_SHIFT: begin
        // read at pointer source, write next cycle
        if (sts.shift_done) begin
          if (sts.cmd == CmdPush) begin
            ctl.wr     = 1'b1;
            ctl.wr_new = 1'b1;
            ctl.inc    = 1'b1;
          end
          ctl.status = StOk;
          state_next = S_RESULT;
        end else begin
          ctl.rd     = 1'b1;
          ctl.dir_up = sts.cmd == CmdPush;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        ctl.wr         = 1'b1;
        ctl.dir_up     = sts.cmd == CmdPush;
        ctl.shift_step = 1'b1;
        state_next     = S_SHIFT;
      end
      S_RESULT: begin
        // hold until the output register is free or being emptied
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### rtl/core/spq_dp.sv
module spq_dp #(
  parameter int QueueDepth = spq_pkg::QueueDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           order_mode,
  input  logic [1:0]           in_cmd,
  input  spq_pkg::entry_t      in_entry,
  input  spq_pkg::ctl_t        ctl,
  output spq_pkg::sts_t        sts,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [111:0]         m_tdata
);
  import spq_pkg::*;

  localparam int AW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);

  logic [1:0]   cmd;
  entry_t       cur, taken;
  logic [CW-1:0] count, idx, pos;
  logic [1:0]   status_r;
  logic         kept_status;
  entry_t       rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic         out_valid;
  logic [111:0] out_data;
  logic [CW-1:0] count_after;

  spq_ram #(.Width(EntryWidth), .Depth(QueueDepth)) u_ram (
    .clk(clk), .we(ctl.wr), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Read address: scan index, or fixed slots for front/back pops; shifts read beside the shift pointer.
  always_comb begin
    raddr = idx[AW-1:0];
    if (ctl.dir_up) raddr = AW'(pos - CW'(1));
    else if (ctl.rd && (cmd == CmdPopFront || cmd == CmdRemove) && kept_status)
      raddr = AW'(pos + CW'(1));
    else if (cmd == CmdPopBack) raddr = AW'(count - CW'(1));
    else if (cmd == CmdPopFront) raddr = '0;
  end

  always_comb begin
    if (ctl.wr_new) begin
      waddr = pos[AW-1:0];
      wdata = cur;
    end else begin
      waddr = pos[AW-1:0];
      wdata = rdata;
    end
  end

  logic pass_push;
  always_comb begin
    case (order_mode)
      ModeFG:    pass_push = (cur.f != rdata.f) ? (cur.f > rdata.f) : (cur.g < rdata.g);
      ModeFifo:  pass_push = cur.f >= rdata.f;
      ModeStack: pass_push = 1'b0;
      default:   pass_push = (cur.depth != rdata.depth) ? (cur.depth < rdata.depth)
                                                        : (cur.f > rdata.f);
    endcase
  end

  always_comb begin
    sts.full       = count >= CW'(QueueDepth);
    sts.empty      = count == '0;
    sts.scan_end   = idx >= count;
    sts.pass       = (cmd == CmdRemove) ? (rdata.handle == cur.handle) : pass_push;
    // output register still holds a beat that is not taken this cycle
    sts.out_busy   = out_valid && !m_tready;
    sts.cmd        = cmd;
    // Insert: pos walks from count down to idx. Delete: pos walks up to count.
    sts.shift_done = (cmd == CmdPush) ? (pos == idx) : (pos + CW'(1) >= count + CW'(1));
  end

  always_comb begin
    count_after = count;
    if (ctl.dec) count_after = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd       <= in_cmd;
      cur       <= in_entry;
      taken     <= '0;
    end
    if (ctl.take) taken <= rdata;
    if (ctl.load) status_r <= StOk;
    else if (ctl.status != StOk) status_r <= ctl.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      idx         <= '0;
      pos         <= '0;
      kept_status <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (ctl.load) begin
        idx         <= '0;
        kept_status <= 1'b0;
      end
      if (ctl.step) idx <= idx + CW'(1);
      if (ctl.set_pos) begin
        kept_status <= 1'b1;
        if (cmd == CmdPush) pos <= count;
        else if (cmd == CmdPopFront) pos <= '0;
        else if (cmd == CmdPopBack) pos <= count - CW'(1);
        else pos <= idx;
      end
      if (ctl.shift_step) begin
        if (ctl.dir_up) pos <= pos - CW'(1);
        else pos <= pos + CW'(1);
      end
      if (ctl.inc) count <= count + CW'(1);
      else if (ctl.dec) count <= count_after;
      if (ctl.out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data <= {7'b0, 7'(count), taken.depth, taken.g, taken.f, taken.handle,
                   status_r};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
endmodule
